// ===== src/srld_pkg.sv =====
// ----------------------------------------------------------------------------
// srld_pkg: shared types and constants for the sprite run-length decoder
// Widths, config register indexes, status codes and the command record
// passed from the parsing front end to the pixel back end.
// ----------------------------------------------------------------------------
package srld_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int SIDE_W    = 7;
  localparam int INDEX_W   = 17;
  localparam int PIX_IDX_W = 12;
  localparam int COUNT_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int TOTAL_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);

  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  // configuration port
  localparam int                  CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 1'd1;
  localparam logic [SIDE_W-1:0]   SIDE_RESET  = 7'd32;

  // end-of-sprite status
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TRUNC    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // command kinds
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_SKIP  = 2'd1;
  localparam logic [1:0] CMD_PIXEL = 2'd2;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic [COUNT_W-1:0] amount;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
    logic               trunc;
  } cmd_t;

  function automatic logic [SIDE_W-1:0] side_limit(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (int'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

endpackage

// ===== src/srld_if.sv =====
// ----------------------------------------------------------------------------
// srld_if: channel interfaces of the sprite run-length decoder
// Encoded byte stream, decoded pixel results and configuration writes.
// ----------------------------------------------------------------------------
interface srld_byte_if;
  logic                           valid;
  logic                           ready;
  logic [srld_pkg::COLOR_W-1:0]   data_byte;
  logic                           last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface srld_pix_if;
  logic                           valid;
  logic                           ready;
  logic                           pixel_valid;
  logic [srld_pkg::PIX_IDX_W-1:0] pixel_index;
  logic [srld_pkg::COLOR_W-1:0]   red;
  logic [srld_pkg::COLOR_W-1:0]   green;
  logic [srld_pkg::COLOR_W-1:0]   blue;
  logic                           sprite_done;
  logic [srld_pkg::STATUS_W-1:0]  status;

  modport source (output valid, pixel_valid, pixel_index, red, green, blue,
                  sprite_done, status, input ready);
  modport sink   (input valid, pixel_valid, pixel_index, red, green, blue,
                  sprite_done, status, output ready);
endinterface

interface srld_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [srld_pkg::CFG_INDEX_W-1:0] index;
  logic [srld_pkg::SIDE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sprite_run_length_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// sprite_run_length_decoder_unit: run-length sprite decoder, top level
// Decodes the transparent/opaque run stream of one sprite into pixel writes
// and an end-of-sprite status.
// ----------------------------------------------------------------------------
// Usage
//   stream : encoded sprite bytes, one per transfer, last_byte on the final
//            byte of each sprite. Runs are tcount(16b LE), ocount(16b LE),
//            then red, green, blue per opaque pixel.
//   pixels : one result per written pixel (pixel_valid=1) and one on the
//            last byte (sprite_done=1, status ok / truncated / overflow);
//            both may share one result. Out-of-range writes are dropped.
//   cfg    : index 0 sprite_width, index 1 sprite_height, 7 bits each,
//            always ready; write only while the decoder is idle.
// Path: a byte's command is registered in the command queue, then its result in the output register.
// Throughput: one byte per cycle while the command queue has room, set by the
//   combinational parser step and index add/bounds compare in the back end.
// Reset: synchronous; clears parser and queue, size registers become 32x32.
// Stall: the output register holds its result; a 4-entry command queue
//   keeps the parser running, and stream.ready drops once it is full.
// ----------------------------------------------------------------------------
module sprite_run_length_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  srld_byte_if.sink   stream,
  srld_pix_if.source  pixels,
  srld_cfg_if.sink    cfg
);

  // front end -> queue
  logic           push;
  srld_pkg::cmd_t push_cmd;
  logic           q_full;

  // queue -> back end
  logic           head_valid;
  srld_pkg::cmd_t head;
  logic           pop;

  // parser: one byte per cycle while the queue has room
  srld_front u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // decouples parsing from result backpressure
  srld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // index tracking, bounds check, status and output register
  srld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixels     (pixels),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

endmodule

// ===== src/srld_front.sv =====
// ----------------------------------------------------------------------------
// srld_front: stream parser
// Walks the run fields byte by byte and turns each completed field into a command:
// index skip, pixel write, or a bare end-of-sprite marker.
// ----------------------------------------------------------------------------
module srld_front (
  input  logic            clk,
  input  logic            rst,
  srld_byte_if.sink       stream,
  input  logic            q_full,
  output logic            push,
  output srld_pkg::cmd_t  cmd
);

  localparam logic [2:0] PH_TLO = 3'd0;
  localparam logic [2:0] PH_THI = 3'd1;
  localparam logic [2:0] PH_OLO = 3'd2;
  localparam logic [2:0] PH_OHI = 3'd3;
  localparam logic [2:0] PH_RED = 3'd4;
  localparam logic [2:0] PH_GRN = 3'd5;
  localparam logic [2:0] PH_BLU = 3'd6;

  logic [2:0]                     phase, phase_next;
  logic [srld_pkg::COLOR_W-1:0]   tlo, tlo_next;
  logic [srld_pkg::COLOR_W-1:0]   olo, olo_next;
  logic [srld_pkg::COLOR_W-1:0]   hred, hred_next;
  logic [srld_pkg::COLOR_W-1:0]   hgreen, hgreen_next;
  logic [srld_pkg::COUNT_W-1:0]   rem, rem_next, rem_dec;
  logic                           accept;
  logic [1:0]                     kind;
  logic [2:0]                     phase_step;

  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;
  assign rem_dec      = rem - srld_pkg::COUNT_W'(1);

  always_comb begin
    tlo_next    = tlo;
    olo_next    = olo;
    hred_next   = hred;
    hgreen_next = hgreen;
    rem_next    = rem;
    kind        = srld_pkg::CMD_NONE;
    phase_step  = phase;
    unique case (phase)
      PH_TLO: begin
        tlo_next   = stream.data_byte;
        phase_step = PH_THI;
      end
      PH_THI: begin
        kind       = srld_pkg::CMD_SKIP;
        phase_step = PH_OLO;
      end
      PH_OLO: begin
        olo_next   = stream.data_byte;
        phase_step = PH_OHI;
      end
      PH_OHI: begin
        rem_next   = {stream.data_byte, olo};
        phase_step = (rem_next == '0) ? PH_TLO : PH_RED;
      end
      PH_RED: begin
        hred_next  = stream.data_byte;
        phase_step = PH_GRN;
      end
      PH_GRN: begin
        hgreen_next = stream.data_byte;
        phase_step  = PH_BLU;
      end
      default: begin
        // blue byte completes a triplet
        kind       = srld_pkg::CMD_PIXEL;
        rem_next   = rem_dec;
        phase_step = (rem_dec == '0) ? PH_TLO : PH_RED;
      end
    endcase
    phase_next = phase_step;
    if (stream.last_byte) begin
      phase_next = PH_TLO;
      rem_next   = '0;
    end
  end

  always_comb begin
    cmd.kind   = kind;
    cmd.amount = {stream.data_byte, tlo};
    cmd.red    = hred;
    cmd.green  = hgreen;
    cmd.blue   = stream.data_byte;
    cmd.last   = stream.last_byte;
    cmd.trunc  = stream.last_byte && (phase_step != PH_TLO);
  end

  assign push = accept && ((kind != srld_pkg::CMD_NONE) || stream.last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TLO;
      rem   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      rem   <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tlo    <= tlo_next;
      olo    <= olo_next;
      hred   <= hred_next;
      hgreen <= hgreen_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && stream.last_byte) |=> (phase == PH_TLO && rem == '0))
    else $error("parser not back at run start after last byte");

endmodule

// ===== src/srld_queue.sv =====
// ----------------------------------------------------------------------------
// srld_queue: command queue
// Small register FIFO between parser and pixel back end.
// ----------------------------------------------------------------------------
module srld_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srld_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output srld_pkg::cmd_t  head
);

  srld_pkg::cmd_t              mem [srld_pkg::QUEUE_DEPTH];
  logic [srld_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [srld_pkg::QCNT_W-1:0] count, count_next;

  assign full       = (count == srld_pkg::QCNT_W'(srld_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + srld_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - srld_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == srld_pkg::QUEUE_DEPTH - 1) ?
                  '0 : wr_ptr + srld_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == srld_pkg::QUEUE_DEPTH - 1) ?
                  '0 : rd_ptr + srld_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full command queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty command queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= srld_pkg::QUEUE_DEPTH)
    else $error("command queue count out of range");

endmodule

// ===== src/srld_back.sv =====
// ----------------------------------------------------------------------------
// srld_back: pixel back end
// Holds the size registers and the pixel index, checks bounds, builds the
// result and keeps it in the output register until transferred.
// ----------------------------------------------------------------------------
module srld_back (
  input  logic            clk,
  input  logic            rst,
  srld_cfg_if.sink        cfg,
  srld_pix_if.source      pixels,
  input  logic            head_valid,
  input  srld_pkg::cmd_t  head,
  output logic            pop
);

  logic [srld_pkg::SIDE_W-1:0]    width, height;
  logic [srld_pkg::SIDE_W-1:0]    w_lim, h_lim;
  logic [2*srld_pkg::SIDE_W-1:0]  area;
  logic [srld_pkg::TOTAL_W-1:0]   total;
  logic [srld_pkg::INDEX_W-1:0]   next_index, index_next;
  logic [srld_pkg::INDEX_W:0]     index_sum;
  logic [srld_pkg::COUNT_W-1:0]   step;
  logic                           overflow_seen;
  logic                           in_range, wrote, produce, out_free, ovf_now;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= srld_pkg::SIDE_RESET;
      height <= srld_pkg::SIDE_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == srld_pkg::REG_WIDTH) begin
        width <= cfg.data;
      end
      if (cfg.index == srld_pkg::REG_HEIGHT) begin
        height <= cfg.data;
      end
    end
  end

  assign w_lim = srld_pkg::side_limit(width);
  assign h_lim = srld_pkg::side_limit(height);
  assign area  = w_lim * h_lim;
  assign total = srld_pkg::TOTAL_W'(area);

  assign in_range = (next_index < srld_pkg::INDEX_W'(total));
  assign wrote    = (head.kind == srld_pkg::CMD_PIXEL) && in_range;
  assign ovf_now  = (head.kind == srld_pkg::CMD_PIXEL) && !in_range;
  assign produce  = wrote || head.last;
  assign out_free = !pixels.valid || pixels.ready;
  assign pop      = head_valid && (!produce || out_free);

  // saturating index advance
  always_comb begin
    unique case (head.kind)
      srld_pkg::CMD_SKIP:  step = head.amount;
      srld_pkg::CMD_PIXEL: step = srld_pkg::COUNT_W'(1);
      default:             step = '0;
    endcase
    index_sum  = {1'b0, next_index} + (srld_pkg::INDEX_W + 1)'(step);
    index_next = index_sum[srld_pkg::INDEX_W] ?
                 srld_pkg::INDEX_MAX : index_sum[srld_pkg::INDEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_index    <= '0;
      overflow_seen <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        next_index    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        next_index    <= index_next;
        overflow_seen <= overflow_seen || ovf_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (pop && produce) begin
      pixels.valid <= 1'b1;
    end else if (pixels.ready) begin
      pixels.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      pixels.pixel_valid <= wrote;
      pixels.pixel_index <= wrote ? next_index[srld_pkg::PIX_IDX_W-1:0] : '0;
      pixels.red         <= wrote ? head.red   : '0;
      pixels.green       <= wrote ? head.green : '0;
      pixels.blue        <= wrote ? head.blue  : '0;
      pixels.sprite_done <= head.last;
      if (!head.last) begin
        pixels.status <= srld_pkg::STATUS_OK;
      end else if (head.trunc) begin
        pixels.status <= srld_pkg::STATUS_TRUNC;
      end else if (overflow_seen || ovf_now) begin
        pixels.status <= srld_pkg::STATUS_OVERFLOW;
      end else begin
        pixels.status <= srld_pkg::STATUS_OK;
      end
    end
  end

  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && !pixels.sprite_done) |-> pixels.status == srld_pkg::STATUS_OK)
    else $error("status set on a result that is not end of sprite");

  a_result_not_lost: assert property (@(posedge clk) disable iff (rst)
    (pop && produce) |-> out_free)
    else $error("result loaded over one not yet transferred");

  a_sprite_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (next_index == '0 && !overflow_seen))
    else $error("index state not cleared after end of sprite");

endmodule
